// File: src/mrl_pkg.sv
// ----------------------------------------------------------------------------
// mrl_pkg: shared types and constants for the masked route lookup
// Route entry layout, search token carried along the cell chain, result item.
// ----------------------------------------------------------------------------
package mrl_pkg;

   localparam int ADDR_W  = 16;
   localparam int METRIC_W = 8;
   localparam int IFACE_W = 8;
   localparam int CNT_W   = 6;

   // opcode field
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef logic [CNT_W-1:0] count_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   dest;
      logic [ADDR_W-1:0]   mask;
      logic [ADDR_W-1:0]   gateway;
      logic [METRIC_W-1:0] metric;
      logic [IFACE_W-1:0]  iface;
   } entry_type;

   // partial search result handed from cell to cell
   typedef struct packed {
      logic [ADDR_W-1:0]   dest;
      count_type           left;        // entries still to search
      logic                local_hit;
      logic                have_remote;
      logic [METRIC_W-1:0] metric;
      logic [IFACE_W-1:0]  iface;
   } search_type;

   typedef struct packed {
      logic               found;
      logic [IFACE_W-1:0] iface;
      logic               local_hit;
   } result_type;

endpackage

// File: src/mrl_cell.sv
// ----------------------------------------------------------------------------
// mrl_cell: one route table slot in the search chain
// Stores one entry and updates the passing search token against it.
// ----------------------------------------------------------------------------
module mrl_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en_i,
   input  mrl_pkg::entry_type  wr_entry_i,
   input  logic                vld_i,
   input  mrl_pkg::search_type tok_i,
   output logic                vld_o,
   output mrl_pkg::search_type tok_o
);

   mrl_pkg::entry_type  entry_ff, entry_in;
   mrl_pkg::search_type tok_ff, tok_in;
   logic                vld_ff, vld_in;
   logic                hit;
   logic                in_use;

   always_comb begin
      entry_in = wr_en_i ? wr_entry_i : entry_ff;
      vld_in   = vld_i;
      hit      = ((tok_i.dest ^ entry_ff.dest) & entry_ff.mask) == '0;
      in_use   = tok_i.left != '0;
      tok_in   = tok_i;
      if (in_use) begin
         tok_in.left = tok_i.left - mrl_pkg::count_type'(1);
         // once a local route is taken, later slots change nothing
         if (hit && !tok_i.local_hit) begin
            if (entry_ff.gateway == '0) begin
               tok_in.local_hit = 1'b1;
               tok_in.iface     = entry_ff.iface;
            end else if (!tok_i.have_remote || (entry_ff.metric < tok_i.metric)) begin
               tok_in.have_remote = 1'b1;
               tok_in.metric      = entry_ff.metric;
               tok_in.iface       = entry_ff.iface;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      tok_ff   <= tok_in;
   end

   assign vld_o = vld_ff;
   assign tok_o = tok_ff;

endmodule

// File: src/masked_route_lookup_top.sv
// ----------------------------------------------------------------------------
// masked_route_lookup_top: route table with masked, min-metric lookup
// A chain of table cells; a lookup token walks the chain one cell per cycle.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   req     | in        | req_valid/req_stall  | opcode, entry fields, lookup
//   rsp     | out       | rsp_valid/rsp_stall  | found, out_iface, local_hit
//   csr     | in        | csr_wr_en            | entries_in_use (6 bits)
//
// Order: a write item updates its cell's entry register. A lookup token walks the
//   TABLE_DEPTH cell registers in turn, then its result goes to the output register,
//   or to the hold register behind a stalled one; no new item enters until it leaves.
// Reset: synchronous; clears entries_in_use, all valids; table undefined.
// Stalls: every item waits while a lookup is in the chain; lookups also wait
//   while the hold register behind a stalled output register is full.
// ----------------------------------------------------------------------------
module masked_route_lookup_top #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [4:0]  req_entry_index,
   input  logic [15:0] req_entry_dest,
   input  logic [15:0] req_entry_mask,
   input  logic [15:0] req_entry_gateway,
   input  logic [7:0]  req_entry_metric,
   input  logic [7:0]  req_entry_iface,
   input  logic [15:0] req_lookup_dest,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [7:0]  rsp_out_iface,
   output logic        rsp_local_hit,
   // configuration
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data
);

   // configuration register
   mrl_pkg::count_type  cnt_ff, cnt_in;

   // sequencing
   logic                busy_ff, busy_in;
   logic                req_fire;
   logic                wr_fire;
   logic                lookup_fire;

   // cell chain: index 0 is the injected token, TABLE_DEPTH the tail
   logic [TABLE_DEPTH:0] chain_vld;
   mrl_pkg::search_type  chain_tok [TABLE_DEPTH+1];
   logic [TABLE_DEPTH-1:0] cell_wr;
   mrl_pkg::entry_type   wr_entry;

   // tail result and output slots
   logic                 tail_vld;
   mrl_pkg::result_type  tail_res;
   logic                 rsp_free;
   logic                 rsp_valid_ff, rsp_valid_in;
   mrl_pkg::result_type  rsp_ff, rsp_in;
   logic                 hold_valid_ff, hold_valid_in;
   mrl_pkg::result_type  hold_ff, hold_in;

   // ---- request side ----
   // one item in the chain at a time; a lookup also needs a free hold slot
   assign req_stall   = busy_ff || ((req_opcode == mrl_pkg::OP_LOOKUP) && hold_valid_ff);
   assign req_fire    = req_valid && !req_stall;
   assign wr_fire     = req_fire && (req_opcode == mrl_pkg::OP_WRITE);
   assign lookup_fire = req_fire && (req_opcode == mrl_pkg::OP_LOOKUP);

   always_comb begin
      cnt_in = csr_wr_en ? csr_wr_data : cnt_ff;
      busy_in = busy_ff;
      if (lookup_fire) begin
         busy_in = 1'b1;
      end else if (tail_vld) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      wr_entry.dest    = req_entry_dest;
      wr_entry.mask    = req_entry_mask;
      wr_entry.gateway = req_entry_gateway;
      wr_entry.metric  = req_entry_metric;
      wr_entry.iface   = req_entry_iface;
   end

   // fresh token: nothing matched yet, count of entries to search
   assign chain_vld[0]             = lookup_fire;
   assign chain_tok[0].dest        = req_lookup_dest;
   assign chain_tok[0].left        = cnt_ff;
   assign chain_tok[0].local_hit   = 1'b0;
   assign chain_tok[0].have_remote = 1'b0;
   assign chain_tok[0].metric      = '0;
   assign chain_tok[0].iface       = '0;

   // ---- cell chain ----
   // slots at or past TABLE_DEPTH simply have no cell, so such writes drop;
   // the chain length also caps the searched count at TABLE_DEPTH
   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      assign cell_wr[g] = wr_fire && (32'(req_entry_index) == g);

      mrl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr_en_i    (cell_wr[g]),
         .wr_entry_i (wr_entry),
         .vld_i      (chain_vld[g]),
         .tok_i      (chain_tok[g]),
         .vld_o      (chain_vld[g+1]),
         .tok_o      (chain_tok[g+1])
      );
   end

   // ---- result side ----
   assign tail_vld           = chain_vld[TABLE_DEPTH];
   assign tail_res.found     = chain_tok[TABLE_DEPTH].local_hit ||
                               chain_tok[TABLE_DEPTH].have_remote;
   assign tail_res.iface     = chain_tok[TABLE_DEPTH].iface;  // stays 0 on a miss
   assign tail_res.local_hit = chain_tok[TABLE_DEPTH].local_hit;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      if (rsp_free) begin
         if (hold_valid_ff) begin
            // older result goes first
            rsp_valid_in  = 1'b1;
            rsp_in        = hold_ff;
            hold_valid_in = tail_vld;
            hold_in       = tail_res;
         end else begin
            rsp_valid_in  = tail_vld;
            rsp_in        = tail_res;
         end
      end else if (tail_vld) begin
         hold_valid_in = 1'b1;
         hold_in       = tail_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      hold_ff <= hold_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_ff.found;
   assign rsp_out_iface = rsp_ff.iface;
   assign rsp_local_hit = rsp_ff.local_hit;

`ifndef NO_ASSERTIONS
   // never more than one token inside the chain
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(chain_vld[TABLE_DEPTH:1]) <= 1)
      else $error("more than one search token in the chain");

   // a token only reaches the tail while a lookup is outstanding
   a_tail_busy: assert property (@(posedge clock) disable iff (reset)
      tail_vld |-> busy_ff)
      else $error("tail token without an outstanding lookup");

   // an idle block has an empty chain
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (chain_vld[TABLE_DEPTH:1] == '0))
      else $error("token in chain while idle");

   // accepted lookup marks the block busy
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      lookup_fire |=> busy_ff)
      else $error("lookup accepted but block not busy");

   // hold slot only fills behind a full output register
   a_hold_order: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> rsp_valid_ff)
      else $error("hold slot full with empty output register");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for masked_route_lookup_top
// Directed routes first, then random route writes and lookups over a sweep of
// entry counts, then a long response hold-off. Every lookup is predicted at
// acceptance and checked field by field against the result items in order.
// ----------------------------------------------------------------------------
module tb;

   localparam int TABLE_DEPTH  = 32;
   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 10;
   // a lookup walks the whole cell chain, plus output and hold slots
   localparam int SETTLE_CYCLES  = TABLE_DEPTH + 8;
   localparam int DRAIN_LIMIT    = 5000;
   localparam int LONG_HOLD      = 300;
   localparam int PHASE_ITEMS    = 180;
   localparam int TIMEOUT_CYCLES = 1_000_000;

   // one request item as the bench builds it
   typedef struct {
      logic               opcode;
      logic [4:0]         index;
      mrl_pkg::entry_type entry;
      logic [15:0]        lookup_dest;
   } route_req_type;

   // ------------------------------------------------------------------------
   // clock, reset and block inputs, all known from time zero
   // ------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid         = 1'b0;
   logic        req_stall;
   logic        req_opcode        = mrl_pkg::OP_WRITE;
   logic [4:0]  req_entry_index   = '0;
   logic [15:0] req_entry_dest    = '0;
   logic [15:0] req_entry_mask    = '0;
   logic [15:0] req_entry_gateway = '0;
   logic [7:0]  req_entry_metric  = '0;
   logic [7:0]  req_entry_iface   = '0;
   logic [15:0] req_lookup_dest   = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_found;
   logic [7:0]  rsp_out_iface;
   logic        rsp_local_hit;

   logic        csr_wr_en   = 1'b0;
   logic [5:0]  csr_wr_data = '0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   masked_route_lookup_top #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_entry_index   (req_entry_index),
      .req_entry_dest    (req_entry_dest),
      .req_entry_mask    (req_entry_mask),
      .req_entry_gateway (req_entry_gateway),
      .req_entry_metric  (req_entry_metric),
      .req_entry_iface   (req_entry_iface),
      .req_lookup_dest   (req_lookup_dest),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_found         (rsp_found),
      .rsp_out_iface     (rsp_out_iface),
      .rsp_local_hit     (rsp_local_hit),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   // ------------------------------------------------------------------------
   // bench state: mirror of the table and the count, results still due
   // ------------------------------------------------------------------------
   mrl_pkg::entry_type  route_mirror [TABLE_DEPTH];
   mrl_pkg::count_type  route_count = '0;
   mrl_pkg::result_type route_results [$];

   logic idle_on      = 1'b1;   // random gaps on both channels
   logic hold_request = 1'b0;   // asks the receiver for one long hold-off

   int fail_count      = 0;
   int writes_seen     = 0;
   int lookups_seen    = 0;
   int local_seen      = 0;
   int remote_seen     = 0;
   int miss_seen       = 0;
   int in_stall_cycles = 0;

   // gap length: mostly none, some short, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Route choice over the entries in use: the first local match wins at
   // once, else the remote match with the strictly lowest metric, earliest
   // on ties. Counts above the table depth search the whole table.
   function automatic mrl_pkg::result_type predict_route(input logic [15:0] dest);
      mrl_pkg::result_type res;
      int                  limit;
      int                  i;
      logic                have_remote;
      logic [7:0]          best_metric;
      mrl_pkg::entry_type  e;
      res         = '0;
      have_remote = 1'b0;
      best_metric = '0;
      limit = (int'(route_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(route_count);
      for (i = 0; i < limit; i++) begin
         e = route_mirror[i];
         if ((dest & e.mask) == (e.dest & e.mask)) begin
            if (e.gateway == 16'h0000) begin
               res.found     = 1'b1;
               res.iface     = e.iface;
               res.local_hit = 1'b1;
               return res;
            end
            if (!have_remote || e.metric < best_metric) begin
               have_remote = 1'b1;
               best_metric = e.metric;
               res.iface   = e.iface;
            end
         end
      end
      res.found = have_remote;
      if (!have_remote) res.iface = '0;
      return res;
   endfunction

   // random route: prefix masks dominate so lookups match often, small
   // metrics give ties, some zero gateways give local routes
   function automatic mrl_pkg::entry_type make_entry();
      mrl_pkg::entry_type e;
      logic [15:0]        ones;
      e.dest = 16'($urandom);
      case ($urandom_range(0, 9))
         0: begin
            e.mask = 16'hffff;
         end
         1: begin
            e.mask = 16'h0000;
         end
         2, 3, 4: begin
            e.mask = 16'($urandom);
         end
         default: begin
            ones   = 16'hffff;
            e.mask = ~(ones >> $urandom_range(0, 16));
         end
      endcase
      e.gateway = ($urandom_range(0, 99) < 15) ? 16'h0000 : 16'($urandom_range(1, 65535));
      e.metric  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      e.iface   = 8'($urandom);
      return e;
   endfunction

   // lookup address: mostly one that hits a chosen entry in use, else random
   function automatic logic [15:0] pick_dest();
      int                 span;
      mrl_pkg::entry_type e;
      span = (int'(route_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(route_count);
      if (span > 0 && $urandom_range(0, 99) < 65) begin
         e = route_mirror[$urandom_range(0, span - 1)];
         return (e.dest & e.mask) | (16'($urandom) & ~e.mask);
      end
      return 16'($urandom);
   endfunction

   // ------------------------------------------------------------------------
   // sender: valid stays up across back-to-back items and is lowered only at
   // the start of a gap, so each step sees at most one assignment to it.
   // Anything that spends time between items must lower req_valid first.
   // ------------------------------------------------------------------------
   task automatic send_route_req(input route_req_type r);
      int gap;
      gap = idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= r.opcode;
      req_entry_index   <= r.index;
      req_entry_dest    <= r.entry.dest;
      req_entry_mask    <= r.entry.mask;
      req_entry_gateway <= r.entry.gateway;
      req_entry_metric  <= r.entry.metric;
      req_entry_iface   <= r.entry.iface;
      req_lookup_dest   <= r.lookup_dest;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_route(input int slot, input mrl_pkg::entry_type e);
      route_req_type r;
      r.opcode      = mrl_pkg::OP_WRITE;
      r.index       = 5'(slot);
      r.entry       = e;
      r.lookup_dest = 16'($urandom);   // ignored by a write
      send_route_req(r);
   endtask

   task automatic lookup_route(input logic [15:0] dest);
      route_req_type r;
      r.opcode      = mrl_pkg::OP_LOOKUP;
      r.index       = 5'($urandom);    // entry fields are ignored by a lookup
      r.entry       = make_entry();
      r.lookup_dest = dest;
      send_route_req(r);
   endtask

   // entry count changes only with the block idle: no result due, and the
   // chain given time to settle after the last result
   task automatic set_route_count(input mrl_pkg::count_type value);
      req_valid <= 1'b0;
      while (route_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      route_count  = value;
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // hand-built routes: empty search, ties, local after remotes, overwrite,
   // catch-all mask, field extremes
   task automatic test_directed_routes();
      // count is zero after reset: nothing is searched, so nothing is found
      lookup_route(16'h0000);
      lookup_route(16'hffff);

      write_route(0, '{dest: 16'h1200, mask: 16'hff00, gateway: 16'h0001,
                       metric: 8'd200, iface: 8'h11});
      write_route(1, '{dest: 16'h1234, mask: 16'hffff, gateway: 16'hffff,
                       metric: 8'd255, iface: 8'hff});
      write_route(2, '{dest: 16'h1200, mask: 16'hff00, gateway: 16'h0abc,
                       metric: 8'd200, iface: 8'h22});
      // default route: zero mask matches everything, zero gateway is local
      write_route(3, '{dest: 16'hffff, mask: 16'h0000, gateway: 16'h0000,
                       metric: 8'd0, iface: 8'h00});

      // remote only: metric tie between slots 0 and 2, the earlier wins
      set_route_count(6'd3);
      lookup_route(16'h1234);
      lookup_route(16'h12ff);
      lookup_route(16'h5555);          // no match at all

      // default route now in range: local wins even after remote matches
      set_route_count(6'd4);
      lookup_route(16'h5555);
      lookup_route(16'h1234);

      // strictly lower metric on a later slot, yet the default route in range still wins as local
      write_route(1, '{dest: 16'h1234, mask: 16'hffff, gateway: 16'hffff,
                       metric: 8'd0, iface: 8'hff});
      lookup_route(16'h1234);
      // first local match chosen at once, ahead of the default route
      write_route(0, '{dest: 16'h1200, mask: 16'hff00, gateway: 16'h0000,
                       metric: 8'd255, iface: 8'h44});
      lookup_route(16'h12aa);
      lookup_route(16'h0000);
   endtask

   // fill every slot first, then sweep the count: full table, single entry,
   // saturated counts, a partial one, zero, and a random one; one phase runs without gaps
   task automatic test_random_routes();
      mrl_pkg::count_type phase_counts [7];
      int                 p;
      int                 n;
      phase_counts = '{6'd32, 6'd1, 6'd63, 6'd17, 6'd0, 6'd33,
                       mrl_pkg::count_type'($urandom_range(0, 63))};
      for (n = 0; n < TABLE_DEPTH; n++) write_route(n, make_entry());
      for (p = 0; p < 7; p++) begin
         set_route_count(phase_counts[p]);
         idle_on = (p != 2);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 30) begin
               write_route($urandom_range(0, TABLE_DEPTH - 1), make_entry());
            end else begin
               lookup_route(pick_dest());
            end
         end
      end
      idle_on = 1'b1;
   endtask

   // receiver holds off for a long stretch while lookups keep coming, so the
   // output and hold slots fill and the request side stalls
   task automatic test_input_backpressure();
      int n;
      set_route_count(6'd32);
      idle_on      = 1'b0;
      hold_request <= 1'b1;
      for (n = 0; n < 10; n++) lookup_route(pick_dest());
      idle_on = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // receiver: random stalls, or one counted long hold-off on request
   // ------------------------------------------------------------------------
   initial begin : receiver
      int n;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request <= 1'b0;
            rsp_stall    <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall    <= 1'b0;
         end else begin
            n = idle_on ? pick_gap() : 0;
            if (n == 0) begin
               rsp_stall <= 1'b0;
            end else begin
               rsp_stall <= 1'b1;
               repeat (n - 1) @(posedge clock);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // request monitor: mirror writes, predict each accepted lookup
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : req_monitor
      mrl_pkg::result_type res;
      if (!reset && req_valid && req_stall) in_stall_cycles++;
      if (!reset && req_valid && !req_stall) begin
         if (req_opcode == mrl_pkg::OP_WRITE) begin
            route_mirror[req_entry_index] = '{dest: req_entry_dest, mask: req_entry_mask,
                                             gateway: req_entry_gateway,
                                             metric: req_entry_metric,
                                             iface: req_entry_iface};
            writes_seen++;
         end else begin
            res = predict_route(req_lookup_dest);
            route_results.push_back(res);
            lookups_seen++;
            if (!res.found) miss_seen++;
            else if (res.local_hit) local_seen++;
            else remote_seen++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // result checker: each accepted result against the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_checker
      mrl_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (route_results.size() == 0) begin
            $error("unexpected result item: found %0d out_iface %0d local_hit %0d",
                   rsp_found, rsp_out_iface, rsp_local_hit);
            fail_count++;
         end else begin
            want = route_results.pop_front();
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_found);
               fail_count++;
            end
            if (rsp_out_iface !== want.iface) begin
               $error("out_iface: expected %0d, actual %0d", want.iface, rsp_out_iface);
               fail_count++;
            end
            if (rsp_local_hit !== want.local_hit) begin
               $error("local_hit: expected %0d, actual %0d", want.local_hit, rsp_local_hit);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : main
      int c;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_directed_routes();
      test_random_routes();
      test_input_backpressure();

      // drain: wait for every due result, bounded, then let the chain settle
      req_valid <= 1'b0;
      for (c = 0; c < DRAIN_LIMIT && route_results.size() != 0; c++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (route_results.size() != 0) begin
         $error("%0d result items never arrived", route_results.size());
         fail_count += route_results.size();
      end

      $display("Covered %0d route writes and %0d lookups: %0d local, %0d remote, %0d misses.",
               writes_seen, lookups_seen, local_seen, remote_seen, miss_seen);
      $display("Entry counts swept from 0 to 63; request side stalled for %0d cycles.",
               in_stall_cycles);
      if (fail_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("tb NOT OK");
      $finish;
   end

endmodule
